[design/gq_pkg.sv]
// ----------------------------------------------------------------------------
// gq_pkg: shared types and constants for the GELU / bucket-index packer
// Item structs, queue entry, divider handshake and fixed-point constants.
// ----------------------------------------------------------------------------
package gq_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int IDX_BITS_W = 2;
	localparam int MAX_IBITS  = 3;
	localparam int NBOUND     = (1 << MAX_IBITS) - 1;
	localparam int CFG_IDX_W  = 3;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BOUNDARY_0 = 3'd1;

	// Divider widths
	localparam int DIV_NUM_W = 61;
	localparam int DIV_DEN_W = 34;
	localparam int DIV_QUO_W = 31;
	localparam int DIV_CNT_W = 6;

	// Q30 constants
	localparam logic [32:0] P_Q30          = 33'd248723596;
	localparam logic [32:0] LOG2E_Q30      = 33'd1549082005;
	localparam logic [32:0] LN2_Q30        = 33'd744261118;
	localparam logic [32:0] INVSQRT2PI_Q30 = 33'd428361012;
	localparam logic signed [34:0] B1_Q30 = 35'sd342933307;
	localparam logic signed [34:0] B2_Q30 = -35'sd382857446;
	localparam logic signed [34:0] B3_Q30 = 35'sd1912847369;
	localparam logic signed [34:0] B4_Q30 = -35'sd1955558716;
	localparam logic signed [34:0] B5_Q30 = 35'sd1428371292;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       final_sample;
	} smp_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] activation;
		logic [15:0]                packed_bytes;
		logic [1:0]                 byte_count;
		logic                       final_result;
	} res_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic [15:0]                packed_bytes;
		logic [1:0]                 byte_count;
		logic                       final_flag;
	} q_entry_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
		logic [DIV_CNT_W-1:0] iters;
	} div_req_t;

	typedef struct packed {
		logic                 busy;
		logic                 done;
		logic [DIV_QUO_W-1:0] quo;
	} div_rsp_t;

endpackage

[design/gq_fifo.sv]
// ----------------------------------------------------------------------------
// gq_fifo: small queue between front and back
// Holds classified items so the front and the GELU engine stall independently.
// ----------------------------------------------------------------------------
module gq_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  gq_pkg::q_entry_t  push_entry,
	input  logic              pop,
	output gq_pkg::q_entry_t  pop_entry,
	output logic              full,
	output logic              empty
);
	import gq_pkg::*;

	q_entry_t             mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q;
	logic [FIFO_AW-1:0]   rd_ptr_q;
	logic [FIFO_AW:0]     count_q;

	assign full      = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign empty     = (count_q == '0);
	assign pop_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (FIFO_AW+1)'(FIFO_DEPTH)) else $error("queue overfilled");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop) else $error("pop from empty queue");

endmodule

[design/gq_front.sv]
// ----------------------------------------------------------------------------
// gq_front: config registers, bucket index and bit packing
// Accepts sample items, counts boundaries below the sample, packs indices
// LSB-first into bytes and pushes the classified item into the queue.
// ----------------------------------------------------------------------------
module gq_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [gq_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [gq_pkg::SAMPLE_W-1:0]          cfg_data,
	input  logic                                 smp_valid,
	output logic                                 smp_ready,
	input  gq_pkg::smp_item_t                    smp_item,
	output logic                                 push,
	output gq_pkg::q_entry_t                     push_entry,
	input  logic                                 full
);
	import gq_pkg::*;

	logic [IDX_BITS_W-1:0]      index_bits_q;
	logic signed [SAMPLE_W-1:0] boundary_q [NBOUND];
	logic [7:0]                 pending_q;
	logic [2:0]                 offset_q;

	logic [1:0]  bits;
	logic [2:0]  ix;
	logic [10:0] word;
	logic [3:0]  off_n;
	logic [15:0] bytes;
	logic [1:0]  cnt;
	logic [7:0]  pend_n;
	logic [2:0]  boff_n;
	logic [NBOUND-1:0] below;

	assign smp_ready = !full;
	assign push      = smp_valid && smp_ready;

	always_comb begin
		case (index_bits_q)
			2'd0:    bits = 2'd1;
			default: bits = index_bits_q;
		endcase
		for (int k = 0; k < NBOUND; k++) begin
			below[k] = (k < ((1 << bits) - 1)) && (boundary_q[k] < smp_item.sample);
		end
		ix = '0;
		for (int k = 0; k < NBOUND; k++) begin
			ix = ix + {2'b0, below[k]};
		end

		word   = {3'b0, pending_q} | ({8'b0, ix} << offset_q);
		off_n  = {1'b0, offset_q} + {2'b0, bits};
		bytes  = '0;
		cnt    = '0;
		if (off_n >= 4'd8) begin
			bytes = {8'b0, word[7:0]};
			cnt   = 2'd1;
			word  = word >> 8;
			off_n = off_n - 4'd8;
		end
		pend_n = word[7:0];
		boff_n = off_n[2:0];
		if (smp_item.final_sample && (boff_n != '0)) begin
			if (cnt == 2'd1) begin
				bytes[15:8] = pend_n;
			end else begin
				bytes[7:0] = pend_n;
			end
			cnt = cnt + 2'd1;
		end
		if (smp_item.final_sample) begin
			pend_n = '0;
			boff_n = '0;
		end
	end

	assign push_entry.sample       = smp_item.sample;
	assign push_entry.packed_bytes = bytes;
	assign push_entry.byte_count   = cnt;
	assign push_entry.final_flag   = smp_item.final_sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_bits_q <= 2'd1;
			boundary_q[0] <= '0;
			for (int k = 1; k < NBOUND; k++) begin
				boundary_q[k] <= 16'sh7fff;
			end
			pending_q <= '0;
			offset_q  <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_INDEX_BITS) begin
					index_bits_q <= cfg_data[IDX_BITS_W-1:0];
				end else begin
					boundary_q[cfg_index - CFG_BOUNDARY_0] <= cfg_data;
				end
			end
			if (push) begin
				pending_q <= pend_n;
				offset_q  <= boff_n;
			end
		end
	end

	a_two_bytes_final: assert property (@(posedge clk) disable iff (!arst_n)
		(push && push_entry.byte_count == 2'd2) |-> push_entry.final_flag)
		else $error("two bytes without final");
	a_final_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(push && smp_item.final_sample) |=> (offset_q == '0 && pending_q == '0))
		else $error("final did not clear packing state");

endmodule

[design/gq_div.sv]
// ----------------------------------------------------------------------------
// gq_div: restoring divider, one quotient bit per cycle
// Consumes numerator bits from the MSB for a given number of iterations.
// ----------------------------------------------------------------------------
module gq_div (
	input  logic              clk,
	input  logic              arst_n,
	input  gq_pkg::div_req_t  req,
	output gq_pkg::div_rsp_t  rsp
);
	import gq_pkg::*;

	logic [DIV_NUM_W-1:0] num_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_QUO_W-1:0] quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [DIV_DEN_W:0]   trial;
	logic [DIV_DEN_W:0]   diff;
	logic                 qbit;

	assign trial = {rem_q, num_q[DIV_NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign qbit  = (trial >= {1'b0, den_q});

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			rem_q <= qbit ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
			quo_q <= {quo_q[DIV_QUO_W-2:0], qbit};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.iters;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q) else $error("divider restarted while busy");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done_q) |-> $past(busy_q)) else $error("done without work");

endmodule

[design/gq_back.sv]
// ----------------------------------------------------------------------------
// gq_back: sequenced GELU engine and result register
// One shared 33x33 multiplier with registered product, a shared divider for
// the rational term and the Taylor steps, then rounding and saturation.
// ----------------------------------------------------------------------------
module gq_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              empty,
	output logic              pop,
	input  gq_pkg::q_entry_t  pop_entry,
	output logic              res_valid,
	input  logic              res_ready,
	output gq_pkg::res_item_t res_item
);
	import gq_pkg::*;

	typedef enum logic [20:0] {
		S_IDLE    = 21'b1 << 0,
		S_PD      = 21'b1 << 1,
		S_DSET    = 21'b1 << 2,
		S_TDIV    = 21'b1 << 3,
		S_HMUL    = 21'b1 << 4,
		S_HADD    = 21'b1 << 5,
		S_AA      = 21'b1 << 6,
		S_W       = 21'b1 << 7,
		S_WSET    = 21'b1 << 8,
		S_G       = 21'b1 << 9,
		S_GSET    = 21'b1 << 10,
		S_TMUL    = 21'b1 << 11,
		S_TDIVS   = 21'b1 << 12,
		S_TWAIT   = 21'b1 << 13,
		S_E       = 21'b1 << 14,
		S_PHI     = 21'b1 << 15,
		S_PHISET  = 21'b1 << 16,
		S_TAILM   = 21'b1 << 17,
		S_TAILSET = 21'b1 << 18,
		S_MM      = 21'b1 << 19,
		S_MSET    = 21'b1 << 20
	} eng_state_t;

	function automatic logic signed [34:0] horner_coef(input logic [2:0] i);
		case (i)
			3'd0:    return B4_Q30;
			3'd1:    return B3_Q30;
			3'd2:    return B2_Q30;
			3'd3:    return B1_Q30;
			default: return '0;
		endcase
	endfunction

	eng_state_t state_q;
	q_entry_t   ent_q;
	logic [15:0] a_q;
	logic [65:0] prod_q;
	logic [30:0] t_q;
	logic signed [34:0] s_q;
	logic [2:0]  hcnt_q;
	logic [8:0]  n_q;
	logic [29:0] f_q;
	logic [30:0] g_q;
	logic [30:0] acc_q;
	logic [3:0]  k_q;
	logic [30:0] e_q;
	logic [32:0] v_q;
	logic        res_valid_q;
	res_item_t   res_q;

	logic [32:0] mul_a;
	logic [32:0] mul_b;
	logic [65:0] rnd_sum;
	logic [35:0] rnd30;
	logic [34:0] s_mag;
	logic signed [34:0] r_s;
	logic signed [34:0] s_next;
	logic [33:0] d_val;
	logic [65:0] y_sum;
	logic [30:0] y_val;
	logic [38:0] w_val;
	logic [31:0] e_val;
	logic [4:0]  sh;
	logic [17:0] m_val;
	logic signed [18:0] y_full;
	logic signed [15:0] y_sat;
	logic        out_free;
	logic        load;
	div_req_t    dreq;
	div_rsp_t    drsp;

	gq_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	assign pop      = (state_q == S_IDLE) && !empty;
	assign out_free = !res_valid_q || res_ready;
	assign load     = (state_q == S_MSET) && out_free;

	// round-to-nearest of a Q30 product
	assign rnd_sum = prod_q + (66'd1 << 29);
	assign rnd30   = rnd_sum[65:30];
	assign s_mag   = s_q[34] ? 35'(-s_q) : 35'(s_q);
	assign r_s     = $signed({1'b0, rnd30[33:0]});

	always_comb begin
		case (state_q)
			S_PD:    begin mul_a = {17'b0, a_q};   mul_b = P_Q30;          end
			S_HMUL:  begin mul_a = s_mag[32:0];    mul_b = {2'b0, t_q};    end
			S_AA:    begin mul_a = {17'b0, a_q};   mul_b = {17'b0, a_q};   end
			S_W:     begin mul_a = prod_q[32:0];   mul_b = LOG2E_Q30;      end
			S_G:     begin mul_a = {3'b0, f_q};    mul_b = LN2_Q30;        end
			S_TMUL:  begin mul_a = {2'b0, g_q};    mul_b = {2'b0, acc_q};  end
			S_PHI:   begin mul_a = {2'b0, e_q};    mul_b = INVSQRT2PI_Q30; end
			S_TAILM: begin mul_a = v_q;            mul_b = s_q[32:0];      end
			// product held while the finished result waits for the output
			S_MM, S_MSET: begin mul_a = {17'b0, a_q}; mul_b = v_q;         end
			default: begin mul_a = '0;             mul_b = '0;             end
		endcase
	end

	always_comb begin
		s_next = horner_coef(hcnt_q) + (s_q[34] ? -r_s : r_s);
		d_val  = 34'(34'd1 << 30) + 34'((prod_q[43:0] + 44'd2048) >> 12);
		y_sum  = prod_q + ({62'b0, k_q} << 29);
		y_val  = y_sum[60:30];
		w_val  = 39'((prod_q + (66'd1 << 24)) >> 25);
		sh     = n_q[4:0];
		if (n_q == '0) begin
			e_val = {1'b0, acc_q};
		end else if (n_q <= 9'd31) begin
			e_val = ({1'b0, acc_q} + (32'd1 << (sh - 5'd1))) >> sh;
		end else begin
			e_val = '0;
		end
		m_val  = rnd30[17:0];
		if (ent_q.sample[15]) begin
			y_full = -$signed({1'b0, m_val});
		end else begin
			y_full = $signed({3'b0, a_q}) - $signed({1'b0, m_val});
		end
		if (y_full > 19'sd32767) begin
			y_sat = 16'sh7fff;
		end else if (y_full < -19'sd32768) begin
			y_sat = 16'sh8000;
		end else begin
			y_sat = y_full[15:0];
		end

		dreq = '0;
		if (state_q == S_DSET) begin
			dreq.start = 1'b1;
			dreq.num   = (61'd1 << 60) + {27'b0, d_val >> 1};
			dreq.den   = d_val;
			dreq.iters = DIV_CNT_W'(61);
		end else if (state_q == S_TDIVS) begin
			dreq.start = 1'b1;
			dreq.num   = {y_val, 30'b0};
			dreq.den   = {30'b0, k_q};
			dreq.iters = DIV_CNT_W'(31);
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (pop) begin
			ent_q <= pop_entry;
			a_q   <= pop_entry.sample[15] ? 16'(-pop_entry.sample) : 16'(pop_entry.sample);
		end
		case (state_q)
			S_TDIV: begin
				t_q    <= drsp.quo;
				s_q    <= B5_Q30;
				hcnt_q <= '0;
			end
			S_HADD: begin
				hcnt_q <= hcnt_q + 3'd1;
				if (hcnt_q == 3'd4 && s_next < 0) begin
					s_q <= '0;
				end else begin
					s_q <= s_next;
				end
			end
			S_WSET: begin
				n_q <= w_val[38:30];
				f_q <= w_val[29:0];
			end
			S_GSET: begin
				g_q   <= rnd30[30:0];
				acc_q <= 31'd1 << 30;
				k_q   <= 4'd10;
			end
			S_TWAIT: begin
				if (drsp.done) begin
					acc_q <= (31'd1 << 30) - drsp.quo;
					k_q   <= k_q - 4'd1;
				end
			end
			S_E:       e_q <= e_val[30:0];
			S_PHISET:  v_q <= rnd30[32:0];
			S_TAILSET: v_q <= rnd30[32:0];
			default: ;
		endcase
		if (load) begin
			res_q.activation   <= y_sat;
			res_q.packed_bytes <= ent_q.packed_bytes;
			res_q.byte_count   <= ent_q.byte_count;
			res_q.final_result <= ent_q.final_flag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE:    if (!empty) state_q <= S_PD;
				S_PD:      state_q <= S_DSET;
				S_DSET:    state_q <= S_TDIV;
				S_TDIV:    if (drsp.done) state_q <= S_HMUL;
				S_HMUL:    state_q <= S_HADD;
				S_HADD:    state_q <= (hcnt_q == 3'd4) ? S_AA : S_HMUL;
				S_AA:      state_q <= S_W;
				S_W:       state_q <= S_WSET;
				S_WSET:    state_q <= S_G;
				S_G:       state_q <= S_GSET;
				S_GSET:    state_q <= S_TMUL;
				S_TMUL:    state_q <= S_TDIVS;
				S_TDIVS:   state_q <= S_TWAIT;
				S_TWAIT: begin
					if (drsp.done) begin
						state_q <= (k_q == 4'd1) ? S_E : S_TMUL;
					end
				end
				S_E:       state_q <= S_PHI;
				S_PHI:     state_q <= S_PHISET;
				S_PHISET:  state_q <= S_TAILM;
				S_TAILM:   state_q <= S_TAILSET;
				S_TAILSET: state_q <= S_MM;
				S_MM:      state_q <= S_MSET;
				S_MSET:    if (out_free) state_q <= S_IDLE;
				default:   state_q <= S_IDLE;
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_q;

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (state_q == S_IDLE)) else $error("pop outside idle");
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> res_valid_q) else $error("result lost");
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TWAIT || state_q == S_TDIV) && !drsp.done |-> drsp.busy)
		else $error("waiting on idle divider");

endmodule

[design/gelu_quantize_bitpack.sv]
// ----------------------------------------------------------------------------
// gelu_quantize_bitpack: GELU in Q3.12 with bucket-index bit packing
// The GELU engine sequence sets the item rate, dominated by ten Taylor
//   steps each waiting on the divider and the divide for the rational term;
//   the engine takes a new item only once the last is in the result register.
// Reset (arst_n low, asynchronous): queue empty, packing state zero,
//   index_bits 1, boundary_0 0, other boundaries 32767.
// ----------------------------------------------------------------------------
module gelu_quantize_bitpack (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write port
	input  logic                          cfg_we,
	input  logic [gq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gq_pkg::SAMPLE_W-1:0]   cfg_data,
	// sample items in
	input  logic                          smp_valid,
	output logic                          smp_ready,
	input  gq_pkg::smp_item_t             smp_item,
	// result items out
	output logic                          res_valid,
	input  logic                          res_ready,
	output gq_pkg::res_item_t             res_item
);
	import gq_pkg::*;

	// Front: classification and packing happen at accept time, so packing
	// state is always current and the item only waits for its activation.
	logic     push;
	q_entry_t push_entry;
	logic     full;
	logic     pop;
	q_entry_t pop_entry;
	logic     empty;

	gq_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.smp_valid  (smp_valid),
		.smp_ready  (smp_ready),
		.smp_item   (smp_item),
		.push       (push),
		.push_entry (push_entry),
		.full       (full)
	);

	// Queue decouples the front, which packs each sample as it is accepted, from the slow engine.
	gq_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.full       (full),
		.empty      (empty)
	);

	// Back: GELU engine; its result register lets the next item start while
	// a finished result waits downstream.
	gq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.pop       (pop),
		.pop_entry (pop_entry),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item)
	);

endmodule
